// ===== sv/deeprc_pkg.sv =====
// ----------------------------------------------------------------------------
// deeprc_pkg
// Types, register codes and defaults for the data EEPROM register controller.
// ----------------------------------------------------------------------------
package deeprc_pkg;

	localparam int          MEM_DEPTH_DEF = 1024;
	localparam logic [15:0] CYC_TICKS_RST = 16'd4;

	// request kinds
	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	// register selects
	localparam logic [2:0] REG_ADRH   = 3'd0;
	localparam logic [2:0] REG_ADRL   = 3'd1;
	localparam logic [2:0] REG_DATA   = 3'd2;
	localparam logic [2:0] REG_CTRL   = 3'd3;
	localparam logic [2:0] REG_UNLOCK = 3'd4;

	// control register bit positions
	localparam int CTL_EEPGD = 7;
	localparam int CTL_CFGS  = 6;
	localparam int CTL_WREN  = 2;
	localparam int CTL_WR    = 1;
	localparam int CTL_RD    = 0;

	// unlock sequence bytes and stages
	localparam logic [7:0] UNLOCK_KEY1 = 8'h55;
	localparam logic [7:0] UNLOCK_KEY2 = 8'hAA;
	localparam logic [1:0] UNL_NONE    = 2'd0;
	localparam logic [1:0] UNL_FIRST   = 2'd1;
	localparam logic [1:0] UNL_ARMED   = 2'd2;

	localparam logic [7:0] ERASED_BYTE = 8'hFF;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear_step;
		logic accept;
		logic load_data;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_done;
		logic rd_go;
	} sts_t;

endpackage

// ===== sv/deeprc_ctrl.sv =====
// ----------------------------------------------------------------------------
// deeprc_ctrl
// Sequencer: erase pass after reset, item handshake, memory read wait state.
// ----------------------------------------------------------------------------
module deeprc_ctrl
	import deeprc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   s_tvalid,
	output logic   s_tready,
	output logic   m_tvalid,
	input  logic   m_tready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt      = state_q;
		cmd.clear_step = 1'b0;
		cmd.accept     = 1'b0;
		cmd.load_data  = 1'b0;
		ready          = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_done) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				// output register frees up in the same cycle it is taken
				ready      = !out_valid_q || m_tready;
				cmd.accept = s_tvalid && ready;
				if (cmd.accept && sts.rd_go) begin
					state_nxt = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load_data = 1'b1;
				state_nxt     = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign s_tready = ready;
	assign m_tvalid = out_valid_q;

endmodule

// ===== sv/deeprc_dpath.sv =====
// ----------------------------------------------------------------------------
// deeprc_dpath
// Bus registers, unlock tracker, write cycle timer, cell memory, result reg.
// ----------------------------------------------------------------------------
module deeprc_dpath
	import deeprc_pkg::*;
#(
	parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [1:0]  req_type,
	input  logic [2:0]  reg_sel,
	input  logic [7:0]  write_data,
	input  logic        cfg_valid,
	input  logic [15:0] cfg_data,
	output logic [7:0]  read_data,
	output logic        write_busy
);

	localparam int AW = $clog2(MEM_DEPTH);
	localparam int DW = AW + 7;

	logic [7:0]    mem [MEM_DEPTH];
	logic [7:0]    mem_rd_q;
	logic [AW-1:0] clr_cnt_q;

	logic [1:0]  adrh_q;
	logic [7:0]  adrl_q;
	logic [7:0]  data_q;
	logic        eepgd_q, cfgs_q, wren_q;
	logic [1:0]  unlock_q;
	logic [15:0] busy_cnt_q;
	logic        active_q;
	logic [15:0] cyc_ticks_q;
	logic [7:0]  rdata_q;
	logic        busy_q;

	req_t          req;
	logic          is_wr, ctl_wr, eeprom_ok;
	logic          wr_go, tick_end;
	logic [AW-1:0] idx;
	logic [7:0]    rdata;
	logic          active_nxt;
	logic [1:0]    unlock_nxt;

	// address modulo depth, restoring style: shifted depth compared and
	// subtracted, largest shift first (address is below 1024, depth >= 8)
	function automatic logic [AW-1:0] cell_idx(input logic [9:0] a);
		logic [DW-1:0] r;
		r = DW'(a);
		for (int k = 6; k >= 0; k--) begin
			if (r >= (DW'(MEM_DEPTH) << k)) begin
				r = r - (DW'(MEM_DEPTH) << k);
			end
		end
		return r[AW-1:0];
	endfunction

	assign req       = req_t'(req_type);
	assign idx       = cell_idx({adrh_q, adrl_q});
	assign is_wr     = cmd.accept && (req == REQ_WRITE);
	assign ctl_wr    = is_wr && (reg_sel == REG_CTRL);
	assign eeprom_ok = !write_data[CTL_EEPGD] && !write_data[CTL_CFGS] && !active_q;
	assign wr_go     = ctl_wr && eeprom_ok && write_data[CTL_WR] &&
	                   write_data[CTL_WREN] && (unlock_q == UNL_ARMED);
	assign tick_end  = (busy_cnt_q <= 16'd1);

	assign sts.rd_go      = (req == REQ_WRITE) && (reg_sel == REG_CTRL) && eeprom_ok &&
	                        write_data[CTL_RD];
	assign sts.clear_done = (clr_cnt_q == AW'(MEM_DEPTH - 1));

	always_comb begin
		rdata = 8'd0;
		if (req == REQ_READ) begin
			case (reg_sel)
				REG_ADRH: rdata = {6'd0, adrh_q};
				REG_ADRL: rdata = adrl_q;
				REG_DATA: rdata = data_q;
				REG_CTRL: rdata = {eepgd_q, cfgs_q, 3'd0, wren_q, active_q, 1'b0};
				default:  rdata = 8'd0;
			endcase
		end
	end

	always_comb begin
		active_nxt = active_q;
		if (wr_go) begin
			active_nxt = 1'b1;
		end else if (cmd.accept && (req == REQ_TICK) && active_q && tick_end) begin
			active_nxt = 1'b0;
		end
	end

	always_comb begin
		unlock_nxt = unlock_q;
		if (is_wr) begin
			if (reg_sel == REG_UNLOCK) begin
				if ((unlock_q == UNL_FIRST) && (write_data == UNLOCK_KEY2)) begin
					unlock_nxt = UNL_ARMED;
				end else if (write_data == UNLOCK_KEY1) begin
					unlock_nxt = UNL_FIRST;
				end else begin
					unlock_nxt = UNL_NONE;
				end
			end else begin
				unlock_nxt = UNL_NONE;
			end
		end
	end

	// cell memory: erase pass after reset, one write port, registered read
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			mem[clr_cnt_q] <= ERASED_BYTE;
		end else if (wr_go && !write_data[CTL_RD]) begin
			// with RD in the same item the cell gets its own value back
			mem[idx] <= data_q;
		end
		mem_rd_q <= mem[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			adrh_q      <= 2'd0;
			adrl_q      <= 8'd0;
			data_q      <= 8'd0;
			eepgd_q     <= 1'b0;
			cfgs_q      <= 1'b0;
			wren_q      <= 1'b0;
			unlock_q    <= UNL_NONE;
			busy_cnt_q  <= 16'd0;
			active_q    <= 1'b0;
			cyc_ticks_q <= CYC_TICKS_RST;
		end else begin
			if (cmd.clear_step) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cfg_valid) begin
				cyc_ticks_q <= cfg_data;
			end
			unlock_q <= unlock_nxt;
			active_q <= active_nxt;
			if (is_wr) begin
				case (reg_sel)
					REG_ADRH: adrh_q <= write_data[1:0];
					REG_ADRL: adrl_q <= write_data;
					REG_DATA: data_q <= write_data;
					REG_CTRL: begin
						eepgd_q <= write_data[CTL_EEPGD];
						cfgs_q  <= write_data[CTL_CFGS];
						wren_q  <= write_data[CTL_WREN];
					end
					default: ;
				endcase
			end
			if (cmd.load_data) begin
				data_q <= mem_rd_q;
			end
			if (wr_go) begin
				busy_cnt_q <= (cyc_ticks_q == 16'd0) ? 16'd1 : cyc_ticks_q;
			end else if (cmd.accept && (req == REQ_TICK) && active_q) begin
				busy_cnt_q <= tick_end ? 16'd0 : busy_cnt_q - 16'd1;
			end
		end
	end

	// result register, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rdata_q <= rdata;
			busy_q  <= active_nxt;
		end
	end

	assign read_data  = rdata_q;
	assign write_busy = busy_q;

endmodule

// ===== sv/data_eeprom_register_controller.sv =====
// ----------------------------------------------------------------------------
// data_eeprom_register_controller
// Data EEPROM behind byte-wide address, data, control and unlock registers.
// ----------------------------------------------------------------------------
// Result: registered when the item is accepted.
// Throughput: one item per cycle unless m_tready stalls; a control write with
//   RD adds a load state waiting on the registered read port of the cell memory.
// Reset: registers clear at once; the memory then takes an erase pass writing
//   0xFF to every cell, during which s_tready stays low.
module data_eeprom_register_controller
	import deeprc_pkg::*;
#(
	parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] write_data
	input  logic [4:0]  s_tuser,  // [1:0] req_type, [4:2] reg_sel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] read_data, [8] write_busy, [15:9] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // write_cycle_ticks
);

	cmd_t       cmd;
	sts_t       sts;
	logic [7:0] read_data;
	logic       write_busy;

	deeprc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	deeprc_dpath #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (s_tuser[1:0]),
		.reg_sel    (s_tuser[4:2]),
		.write_data (s_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.read_data  (read_data),
		.write_busy (write_busy)
	);

	assign cfg_ready = 1'b1;
	assign m_tdata   = {7'd0, write_busy, read_data};

endmodule
